// ===== rtl/ttid_pkg.sv =====
// Package for the timer table with ids: field widths, operation and status codes,
// and the structs that pass between the controller and the row of timer cells.
// No dependencies.
`timescale 1ns / 1ps

package ttid_pkg;

	// Sizes of the table and of the id search.
	localparam int NUM_SLOTS_DEF  = 32;
	localparam int ID_RETRIES_DEF = 10;

	// Field widths.
	localparam int OP_W     = 2;
	localparam int NOW_W    = 48;
	localparam int DELAY_W  = 32;
	localparam int PL_W     = 32;
	localparam int ID_W     = 29;
	localparam int CTR_W    = 28;
	localparam int DL_W     = 49;
	localparam int STATUS_W = 3;

	// Command codes.
	typedef enum logic [OP_W-1:0] {
		OP_CREATE  = 2'd0,
		OP_RELEASE = 2'd1,
		OP_TICK    = 2'd2
	} ttid_op_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_CREATED  = 3'd0,
		ST_FULL     = 3'd1,
		ST_NO_ID    = 3'd2,
		ST_RELEASED = 3'd3,
		ST_UNKNOWN  = 3'd4,
		ST_EXPIRED  = 3'd5,
		ST_NONE     = 3'd6
	} ttid_status_t;

	// Controls broadcast from the controller to every cell.
	typedef struct packed {
		logic             start;       // token enters the first cell
		logic             adv;         // token moves one cell on
		logic             clr;         // token is dropped
		logic             find;        // looking for a free cell
		logic             tick;        // looking for due cells
		logic             rel_en;      // free the cell whose id matches
		logic             wr_en;       // arm the selected cell
		logic             sel_clr;     // drop the selection
		logic [ID_W-1:0]  cmp_id;      // id compared by every cell
		logic [ID_W-1:0]  wr_id;
		logic [DL_W-1:0]  wr_deadline;
		logic [PL_W-1:0]  wr_payload;
		logic [NOW_W-1:0] now;
	} ttid_bcast_t;

	// Status returned by one cell.
	typedef struct packed {
		logic            tok;    // cell holds the token
		logic            sel;    // cell is selected for a create
		logic            free;   // token cell is free during a search
		logic            due;    // token cell has expired during a tick
		logic            match;  // armed cell holds the compared id
		logic [ID_W-1:0] id;     // id of a due cell, zero otherwise
		logic [PL_W-1:0] pl;     // payload of a due cell, zero otherwise
	} ttid_cell_rsp_t;

endpackage

// ===== rtl/ttid_ifs.sv =====
// Valid/ready channel interfaces for commands and results of the timer table.
// Depends on ttid_pkg for field widths.
`timescale 1ns / 1ps

interface ttid_cmd_if;
	import ttid_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       op;
	logic [NOW_W-1:0]      now_msec;
	logic [DELAY_W-1:0]    delay_msec;
	logic [PL_W-1:0]       payload;
	logic [ID_W-1:0]       rel_id;

	modport source (output valid, op, now_msec, delay_msec, payload, rel_id, input ready);
	modport sink (input valid, op, now_msec, delay_msec, payload, rel_id, output ready);
endinterface

interface ttid_rsp_if;
	import ttid_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     result_id;
	logic [PL_W-1:0]     result_payload;
	logic                last;

	modport source (output valid, status, result_id, result_payload, last, input ready);
	modport sink (input valid, status, result_id, result_payload, last, output ready);
endinterface

// ===== rtl/ttid_cell.sv =====
// One timer cell: holds one slot of the table and one stage of the token chain.
// Depends on ttid_pkg.
`timescale 1ns / 1ps

module ttid_cell
	import ttid_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  ttid_bcast_t    bc,
	input  logic           tok_in,
	output ttid_cell_rsp_t rsp
);

	logic            valid_q;
	logic            sel_q;
	logic            tok_q;
	logic [ID_W-1:0] id_q;
	logic [DL_W-1:0] dl_q;
	logic [PL_W-1:0] pl_q;

	logic due;
	logic hit_free;
	logic match;

	// Local decisions: due on a tick, free on a search, id match on a compare.
	assign due      = bc.tick && tok_q && valid_q && (dl_q <= {1'b0, bc.now});
	assign hit_free = bc.find && tok_q && !valid_q;
	assign match    = valid_q && (id_q == bc.cmp_id);

	// Token stage, selection and armed flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			sel_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (bc.clr) begin
				tok_q <= 1'b0;
			end else if (bc.adv) begin
				tok_q <= tok_in;
			end
			if (hit_free) begin
				sel_q <= 1'b1;
			end else if (bc.sel_clr) begin
				sel_q <= 1'b0;
			end
			if (bc.wr_en && sel_q) begin
				valid_q <= 1'b1;
			end else if ((bc.rel_en && match) || (due && bc.adv)) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Slot contents, written when the selected cell is armed.
	always_ff @(posedge clk) begin
		if (bc.wr_en && sel_q) begin
			id_q <= bc.wr_id;
			dl_q <= bc.wr_deadline;
			pl_q <= bc.wr_payload;
		end
	end

	always_comb begin
		rsp       = '0;
		rsp.tok   = tok_q;
		rsp.sel   = sel_q;
		rsp.free  = hit_free;
		rsp.due   = due;
		rsp.match = match;
		rsp.id    = due ? id_q : '0;
		rsp.pl    = due ? pl_q : '0;
	end

endmodule

// ===== rtl/ttid_ctrl.sv =====
// Sequencer of the timer table: takes commands, drives the cell row, draws ids
// and holds the result register. Depends on ttid_pkg and the channel interfaces.
`timescale 1ns / 1ps

module ttid_ctrl
	import ttid_pkg::*;
#(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int ID_RETRIES = ID_RETRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ttid_cmd_if.sink       cmd,
	ttid_rsp_if.source     rsp,
	input  ttid_cell_rsp_t cell_rsp [NUM_SLOTS],
	output ttid_bcast_t    bc
);

	localparam int TRY_W = $clog2(ID_RETRIES + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_FIND = 6'b000010,
		S_DRAW = 6'b000100,
		S_REL  = 6'b001000,
		S_TICK = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

	state_t state_q, state_d;

	logic [NOW_W-1:0]    now_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [PL_W-1:0]     pl_q;
	logic [ID_W-1:0]     tid_q;
	logic [CTR_W-1:0]    ctr_q, ctr_d, cand;
	logic [TRY_W-1:0]    try_q, try_d;
	logic [STATUS_W-1:0] res_st_q, res_st_d;
	logic [ID_W-1:0]     res_id_q, res_id_d;
	logic [PL_W-1:0]     res_pl_q, res_pl_d;

	logic                out_v_q;
	logic [STATUS_W-1:0] out_st_q, out_st;
	logic [ID_W-1:0]     out_id_q, out_id;
	logic [PL_W-1:0]     out_pl_q, out_pl;
	logic                out_last_q, out_last;
	logic                out_ld;
	logic                out_ok;

	logic                 any_free, any_due, any_match;
	logic [ID_W-1:0]      due_id;
	logic [PL_W-1:0]      due_pl;
	logic [NUM_SLOTS-1:0] tok_vec, sel_vec, match_vec;
	logic                 tok_last;
	logic                 pend;
	logic                 accept;

	// Gather the row: only the token cell can report free or due.
	always_comb begin
		any_free  = 1'b0;
		any_due   = 1'b0;
		any_match = 1'b0;
		due_id    = '0;
		due_pl    = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			any_free     = any_free | cell_rsp[i].free;
			any_due      = any_due | cell_rsp[i].due;
			any_match    = any_match | cell_rsp[i].match;
			due_id       = due_id | cell_rsp[i].id;
			due_pl       = due_pl | cell_rsp[i].pl;
			tok_vec[i]   = cell_rsp[i].tok;
			sel_vec[i]   = cell_rsp[i].sel;
			match_vec[i] = cell_rsp[i].match;
		end
	end

	assign tok_last = cell_rsp[NUM_SLOTS-1].tok;
	// The counter is 28 bits wide, so the increment wraps like the masked draw.
	assign cand     = ctr_q + CTR_W'(1);
	assign pend     = (res_st_q == ST_EXPIRED);
	assign out_ok   = !out_v_q || rsp.ready;
	assign accept   = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);

	// Sequencer.
	always_comb begin
		bc             = '0;
		bc.now         = now_q;
		bc.wr_deadline = {1'b0, now_q} + {{(DL_W - DELAY_W){1'b0}}, delay_q};
		bc.wr_id       = {1'b0, cand};
		bc.wr_payload  = pl_q;
		bc.cmp_id      = (state_q == S_REL) ? tid_q : {1'b0, cand};
		state_d        = state_q;
		ctr_d          = ctr_q;
		try_d          = try_q;
		res_st_d       = res_st_q;
		res_id_d       = res_id_q;
		res_pl_d       = res_pl_q;
		out_ld         = 1'b0;
		out_st         = res_st_q;
		out_id         = res_id_q;
		out_pl         = res_pl_q;
		out_last       = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					res_st_d = ST_NONE;
					res_id_d = '0;
					res_pl_d = '0;
					try_d    = '0;
					unique case (cmd.op)
						OP_CREATE: begin
							bc.start = 1'b1;
							bc.adv   = 1'b1;
							state_d  = S_FIND;
						end
						OP_RELEASE: begin
							state_d = S_REL;
						end
						OP_TICK: begin
							bc.start = 1'b1;
							bc.adv   = 1'b1;
							state_d  = S_TICK;
						end
						default: begin
						end
					endcase
				end
			end
			// Walk the token to the lowest free cell.
			S_FIND: begin
				bc.find = 1'b1;
				if (any_free) begin
					bc.clr  = 1'b1;
					state_d = S_DRAW;
				end else begin
					bc.adv = 1'b1;
					if (tok_last) begin
						res_st_d = ST_FULL;
						state_d  = S_RESP;
					end
				end
			end
			// One id draw per cycle, checked against every armed cell at once.
			S_DRAW: begin
				ctr_d = cand;
				if (!any_match) begin
					bc.wr_en   = 1'b1;
					bc.sel_clr = 1'b1;
					res_st_d   = ST_CREATED;
					res_id_d   = {1'b0, cand};
					state_d    = S_RESP;
				end else if (try_q == TRY_W'(ID_RETRIES - 1)) begin
					bc.sel_clr = 1'b1;
					res_st_d   = ST_NO_ID;
					state_d    = S_RESP;
				end else begin
					try_d = try_q + TRY_W'(1);
				end
			end
			S_REL: begin
				bc.rel_en = 1'b1;
				if (any_match) begin
					res_st_d = ST_RELEASED;
					res_id_d = tid_q;
				end else begin
					res_st_d = ST_UNKNOWN;
				end
				state_d = S_RESP;
			end
			// Walk the token over all cells; a due cell is held back one step so
			// that the final one can carry the last flag.
			S_TICK: begin
				bc.tick = 1'b1;
				if (!(any_due && pend && !out_ok)) begin
					bc.adv = 1'b1;
					if (any_due) begin
						res_st_d = ST_EXPIRED;
						res_id_d = due_id;
						res_pl_d = due_pl;
						if (pend) begin
							out_ld   = 1'b1;
							out_last = 1'b0;
						end
					end
					if (tok_last) begin
						state_d = S_RESP;
					end
				end
			end
			S_RESP: begin
				if (out_ok) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ctr_q    <= '0;
			try_q    <= '0;
			res_st_q <= ST_NONE;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			ctr_q    <= ctr_d;
			try_q    <= try_d;
			res_st_q <= res_st_d;
			if (out_ld) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Command capture, pending result and output item.
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q   <= cmd.now_msec;
			delay_q <= cmd.delay_msec;
			pl_q    <= cmd.payload;
			tid_q   <= cmd.rel_id;
		end
		res_id_q <= res_id_d;
		res_pl_q <= res_pl_d;
		if (out_ld) begin
			out_st_q   <= out_st;
			out_id_q   <= out_id;
			out_pl_q   <= out_pl;
			out_last_q <= out_last;
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.status         = out_st_q;
	assign rsp.result_id      = out_id_q;
	assign rsp.result_payload = out_pl_q;
	assign rsp.last           = out_last_q;

	// At most one token travels the row.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec)) else $error("more than one token in the cell row");

	// No token is left behind once a command is done.
	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (tok_vec == '0)) else $error("token left in idle");

	// Armed ids stay unique, so a compare hits at most one cell.
	a_unique_id: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec)) else $error("id held by more than one cell");

	// At most one cell is selected, and only while an id is being drawn.
	a_sel: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_vec) && ((sel_vec == '0) || (state_q == S_DRAW)))
		else $error("bad cell selection");

endmodule

// ===== rtl/timer_table_with_ids.sv =====
// Commands are taken one at a time. A release checks every cell at once; a create walks
// the token down the cell row to a free cell and then draws ids; a tick walks the token
// over every cell, one slot per cycle while the result side does not stall it.
// Reset (asynchronous, active low) empties the table and clears the id counter.
`timescale 1ns / 1ps

module timer_table_with_ids
	import ttid_pkg::*;
#(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int ID_RETRIES = ID_RETRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ttid_cmd_if.sink   cmd,
	ttid_rsp_if.source rsp
);

	ttid_bcast_t    bc;
	ttid_cell_rsp_t cell_rsp [NUM_SLOTS];

	// Row of timer cells; the token passes from each cell to the next.
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		logic tok_in;
		if (i == 0) begin : g_head
			assign tok_in = bc.start;
		end else begin : g_link
			assign tok_in = cell_rsp[i-1].tok;
		end
		ttid_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bc     (bc),
			.tok_in (tok_in),
			.rsp    (cell_rsp[i])
		);
	end

	// Command sequencer and result register.
	ttid_ctrl #(
		.NUM_SLOTS  (NUM_SLOTS),
		.ID_RETRIES (ID_RETRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rsp      (rsp),
		.cell_rsp (cell_rsp),
		.bc       (bc)
	);

endmodule

// ===== tb/timer_table_checker.sv =====
// Checker for the timer table: watches the command and result channels and predicts
// every result from its own model of the timer slots and the id counter.
// Depends on ttid_pkg and the channel interfaces in ttid_ifs.
`timescale 1ns / 1ps

module timer_table_checker
	import ttid_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ttid_cmd_if  cmd,
	ttid_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);

	localparam int SLOTS   = NUM_SLOTS_DEF;
	localparam int RETRIES = ID_RETRIES_DEF;

	typedef struct packed {
		ttid_status_t    status;
		logic [ID_W-1:0] id;
		logic [PL_W-1:0] pl;
		logic            last;
	} timer_result_t;

	// Shadow copy of the timer table.
	logic             armed [SLOTS];
	logic [ID_W-1:0]  armed_id [SLOTS];
	logic [DL_W-1:0]  armed_deadline [SLOTS];
	logic [PL_W-1:0]  armed_payload [SLOTS];
	logic [CTR_W-1:0] id_ctr;

	timer_result_t awaited_results[$];

	function automatic void push_result(ttid_status_t st, logic [ID_W-1:0] id,
			logic [PL_W-1:0] pl);
		timer_result_t r;
		r.status = st;
		r.id     = id;
		r.pl     = pl;
		r.last   = 1'b0;
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	// Returns the slot that holds an armed timer with this id, or -1.
	function automatic int slot_of_id(logic [ID_W-1:0] id);
		int s;
		for (s = 0; s < SLOTS; s++) begin
			if (armed[s] && armed_id[s] == id)
				return s;
		end
		return -1;
	endfunction

	// Applies one accepted command to the shadow table and queues its results.
	task automatic apply_command(logic [OP_W-1:0] op, logic [NOW_W-1:0] now,
			logic [DELAY_W-1:0] delay, logic [PL_W-1:0] pl, logic [ID_W-1:0] tid);
		int s;
		int free_slot;
		int hit;
		int tries;
		int n;
		int size_before;
		bit done;
		timer_result_t tail;
		size_before = awaited_results.size();
		case (op)
			OP_CREATE: begin
				free_slot = -1;
				for (s = SLOTS - 1; s >= 0; s--) begin
					if (!armed[s])
						free_slot = s;
				end
				if (free_slot < 0) begin
					push_result(ST_FULL, '0, '0);
				end else begin
					// Each draw advances the counter; a clash with a live id draws again.
					done = 1'b0;
					for (tries = 0; tries < RETRIES && !done; tries++) begin
						id_ctr = id_ctr + 1'b1;
						if (slot_of_id({1'b0, id_ctr}) < 0) begin
							armed[free_slot]          = 1'b1;
							armed_id[free_slot]       = {1'b0, id_ctr};
							armed_deadline[free_slot] = {1'b0, now} + {17'b0, delay};
							armed_payload[free_slot]  = pl;
							push_result(ST_CREATED, {1'b0, id_ctr}, '0);
							done = 1'b1;
						end
					end
					if (!done)
						push_result(ST_NO_ID, '0, '0);
				end
			end
			OP_RELEASE: begin
				// Ids with the top bit set can never be held by a timer.
				hit = tid[ID_W-1] ? -1 : slot_of_id(tid);
				if (hit < 0) begin
					push_result(ST_UNKNOWN, '0, '0);
				end else begin
					armed[hit] = 1'b0;
					push_result(ST_RELEASED, tid, '0);
				end
			end
			OP_TICK: begin
				n = 0;
				for (s = 0; s < SLOTS; s++) begin
					if (armed[s] && armed_deadline[s] <= {1'b0, now}) begin
						push_result(ST_EXPIRED, armed_id[s], armed_payload[s]);
						armed[s] = 1'b0;
						n++;
					end
				end
				if (n == 0)
					push_result(ST_NONE, '0, '0);
			end
			default: begin
			end
		endcase
		// Mark the final result of this command.
		if (awaited_results.size() > size_before) begin
			tail = awaited_results[awaited_results.size() - 1];
			tail.last = 1'b1;
			awaited_results[awaited_results.size() - 1] = tail;
		end
	endtask

	// Predict on each accepted command and compare each accepted result.
	always @(posedge clk or negedge arst_n) begin
		timer_result_t exp_r;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++)
				armed[s] = 1'b0;
			id_ctr = '0;
			awaited_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cmd.valid && cmd.ready)
				apply_command(cmd.op, cmd.now_msec, cmd.delay_msec, cmd.payload,
					cmd.rel_id);
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: status %0d id %0h payload %0h last %0b",
						$time, rsp.status, rsp.result_id, rsp.result_payload, rsp.last);
				end else begin
					exp_r = awaited_results.pop_front();
					if (rsp.status !== exp_r.status || rsp.result_id !== exp_r.id ||
							rsp.result_payload !== exp_r.pl || rsp.last !== exp_r.last) begin
						fail_count++;
						$display("%0t: result mismatch: expected status %0d id %0h payload %0h last %0b",
							$time, exp_r.status, exp_r.id, exp_r.pl, exp_r.last);
						$display("%0t:                  actual status %0d id %0h payload %0h last %0b",
							$time, rsp.status, rsp.result_id, rsp.result_payload, rsp.last);
					end
				end
			end
			pending = awaited_results.size();
		end
	end

endmodule

// ===== tb/timer_table_with_ids_tb.sv =====
// Top of the timer table testbench: clock, reset, command and result stimulus
// with idle and stall phases, and the final verdict.
// Depends on ttid_pkg, ttid_ifs, timer_table_with_ids and timer_table_checker.
`timescale 1ns / 1ps

module timer_table_with_ids_tb;
	import ttid_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = NUM_SLOTS_DEF + ID_RETRIES_DEF + 8;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 103;
	localparam logic [NOW_W-1:0] NOW_MAX = '1;
	// Operation code that the block ignores.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	bit long_hold = 1'b0;
	int create_count = 0;
	logic [NOW_W-1:0] cur_now = '0;

	ttid_cmd_if cmd_ch ();
	ttid_rsp_if rsp_ch ();

	timer_table_with_ids dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	timer_table_checker table_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the total run length.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Result side: random stalls, and one long hold-off when requested.
	initial begin
		int hold_left;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
					rsp_ch.ready <= 1'b0;
					@(negedge clk);
				end
				long_hold = 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	// Offers one command item, with random idle cycles first, and waits for its acceptance.
	task automatic send_cmd(logic [OP_W-1:0] op, logic [NOW_W-1:0] now,
			logic [DELAY_W-1:0] delay, logic [PL_W-1:0] pl, logic [ID_W-1:0] tid);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.op         <= op;
		cmd_ch.now_msec   <= now;
		cmd_ch.delay_msec <= delay;
		cmd_ch.payload    <= pl;
		cmd_ch.rel_id     <= tid;
		if (op == OP_CREATE)
			create_count++;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// Fills the table past full, then expires everything with one tick.
	task automatic fill_and_flush();
		repeat (NUM_SLOTS_DEF + 2)
			send_cmd(OP_CREATE, cur_now, $urandom_range(0, 1000), $urandom(), '0);
		send_cmd(OP_TICK, NOW_MAX, $urandom(), $urandom(), ID_W'($urandom()));
	endtask

	// One random command: mostly well-formed traffic on a moving clock, some noise.
	task automatic random_item();
		int pick;
		logic [63:0] wide;
		logic [NOW_W-1:0] now_v;
		logic [DELAY_W-1:0] delay_v;
		logic [ID_W-1:0] tid_v;
		pick = $urandom_range(99);
		wide = {$urandom(), $urandom()};
		if (pick < 42) begin
			now_v = ($urandom_range(99) < 5) ? wide[NOW_W-1:0] : cur_now;
			delay_v = ($urandom_range(99) < 6) ? $urandom() : $urandom_range(0, 300);
			send_cmd(OP_CREATE, now_v, delay_v, $urandom(), ID_W'($urandom()));
		end else if (pick < 66) begin
			// Releases mostly aim at recently issued ids.
			if ($urandom_range(99) < 75)
				tid_v = ID_W'($urandom_range(create_count,
					create_count > 40 ? create_count - 40 : 1));
			else
				tid_v = ID_W'($urandom());
			send_cmd(OP_RELEASE, wide[NOW_W-1:0], $urandom(), $urandom(), tid_v);
		end else if (pick < 95) begin
			cur_now = cur_now + $urandom_range(0, 60);
			now_v = ($urandom_range(99) < 3) ? NOW_MAX : cur_now;
			send_cmd(OP_TICK, now_v, $urandom(), $urandom(), ID_W'($urandom()));
		end else begin
			send_cmd(OP_UNUSED, wide[NOW_W-1:0], $urandom(), $urandom(), ID_W'($urandom()));
		end
	endtask

	// Sends about the given number of command items; a fill and flush counts all of its items.
	task automatic run_phase(int src_pct, int snk_pct, int items);
		int sent;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(39) == 0) begin
				fill_and_flush();
				sent += NUM_SLOTS_DEF + 3;
			end else begin
				random_item();
				sent++;
			end
		end
	endtask

	// Reset, directed cases, random phases, drain and verdict.
	initial begin
		arst_n            = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.op         = OP_TICK;
		cmd_ch.now_msec   = '0;
		cmd_ch.delay_msec = '0;
		cmd_ch.payload    = '0;
		cmd_ch.rel_id     = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty table: nothing expires and no id is known, including out-of-range ids.
		send_cmd(OP_TICK, '0, '0, '0, '0);
		send_cmd(OP_RELEASE, '0, '0, '0, '0);
		send_cmd(OP_RELEASE, '0, '0, '0, 29'h1000_0000);
		send_cmd(OP_RELEASE, NOW_MAX, '1, '1, '1);
		// Creates at the field extremes; the largest deadline needs the 49th bit.
		send_cmd(OP_CREATE, '0, '0, '0, '0);
		send_cmd(OP_CREATE, NOW_MAX, '1, '1, '1);
		send_cmd(OP_CREATE, 48'd5, 32'd10, 32'ha5a5_a5a5, '0);
		// The undefined operation is ignored.
		send_cmd(OP_UNUSED, NOW_MAX, '1, '1, '1);
		// A deadline equal to now expires.
		send_cmd(OP_TICK, '0, '0, '0, '0);
		send_cmd(OP_TICK, 48'd15, '0, '0, '0);
		send_cmd(OP_RELEASE, '0, '0, '0, 29'd2);
		send_cmd(OP_RELEASE, '0, '0, '0, 29'd2);
		send_cmd(OP_TICK, NOW_MAX, '0, '0, '0);
		cur_now = 48'd100;

		// Long result hold-off while the sender keeps offering items.
		long_hold = 1'b1;
		fill_and_flush();
		run_phase(0, 0, PHASE_ITEMS);
		run_phase(67, 0, PHASE_ITEMS);
		run_phase(0, 67, PHASE_ITEMS);
		run_phase(8, 8, PHASE_ITEMS);

		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending != 0)
			$display("%0t: %0d expected results never arrived", $time, pending);
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
